/* rtl/bcasmooth_pkg.sv */
// shared constants, types and helpers of the binary cellular automaton smoother
package bcasmooth_pkg;

    localparam int CoordWidth = 7;
    localparam int DimWidth   = 8;
    localparam int SetWidth   = 4;
    localparam int ClearWidth = 5;
    localparam int CountWidth = 4;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 8;

    localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH      = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SET_THRESHOLD   = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_CLEAR_THRESHOLD = 2'd3;

    localparam logic [DimWidth-1:0]   DIM_MIN        = 8'd3;
    localparam logic [DimWidth-1:0]   DIM_MAX        = 8'd128;
    localparam logic [DimWidth-1:0]   RESET_DIM      = 8'd100;
    localparam logic [SetWidth-1:0]   RESET_SET_THR  = 4'd6;
    localparam logic [ClearWidth-1:0] RESET_CLR_THR  = 5'd4;

    typedef logic [8:0] window_t;

    function automatic logic [CountWidth-1:0] pop9(input window_t w);
        logic [CountWidth-1:0] n;
        n = '0;
        for (int i = 0; i < 9; i++) begin
            n = n + CountWidth'(w[i]);
        end
        return n;
    endfunction

endpackage

/* rtl/binary_cellular_automaton_smoother.sv */
// top level of the binary cellular automaton smoother: line stores, 3x3 window, result register
//
//  channel  ports                                              direction
//  s_       s_valid s_ready s_cell_value s_frame_start         in
//  m_       m_valid m_ready m_out_row m_out_col m_new_value    out
//           m_pass_done
//  cfg_     cfg_we cfg_addr cfg_wdata                          in
//
// one cell per cycle unless stalled; a cell's result is registered after the window stage
// the line stores are read at the transfer edge, the window and rule act in the next cycle
// the window recurrence (updated centre feeding the next cell) closes within the window stage
// aresetn is synchronous; line store contents are not cleared, counters and window are
// a stalled result holds an interior cell in the window stage, which holds s_ready low
module binary_cellular_automaton_smoother
    import bcasmooth_pkg::*;
#(
    parameter int MAX_WIDTH = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CfgIdxW-1:0]    cfg_addr,
    input  logic [CfgDataW-1:0]   cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cell_value,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CoordWidth-1:0] m_out_row,
    output logic [CoordWidth-1:0] m_out_col,
    output logic                  m_new_value,
    output logic                  m_pass_done
);

    localparam int LineDepth = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
    localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
    localparam logic [DimWidth-1:0] WidthMax = DimWidth'(LineDepth);

    logic [DimWidth-1:0]   grid_width_reg, grid_height_reg;
    logic [SetWidth-1:0]   set_thr_reg;
    logic [ClearWidth-1:0] clr_thr_reg;

    logic                  original_mem [LineDepth];
    logic                  updated_mem  [LineDepth];

    logic [CoordWidth-1:0] row_cnt_reg, col_cnt_reg;
    window_t               window_reg, window_next;

    logic                  s1_valid_reg, s1_bit_reg, s1_inrange_reg;
    logic                  s1_top_reg, s1_mid_reg;
    logic [CoordWidth-1:0] s1_row_reg, s1_col_reg;

    logic                  pend_wr_reg;
    logic [AddrW-1:0]      pend_addr_reg;
    logic                  pend_data_reg;

    logic                  m_valid_reg, m_new_value_reg, m_pass_done_reg;
    logic [CoordWidth-1:0] m_out_row_reg, m_out_col_reg;

    logic [DimWidth-1:0]   w_eff, h_eff;
    logic [CoordWidth-1:0] w_m1, h_m1;
    logic                  s_xfer;
    logic [CoordWidth-1:0] r0, c0;
    logic                  c0_inrange;
    logic [AddrW-1:0]      rd_addr;

    logic                  top_b, mid_b;
    window_t               shifted;
    logic                  interior;
    logic [CountWidth-1:0] cnt;
    logic                  rule_val;
    logic                  out_free, s1_adv;
    logic [CoordWidth-1:0] s1_col_m1;
    logic                  s1_wr;
    logic                  uwe, uwd;
    logic [AddrW-1:0]      uwa;

    // effective dimensions
    always_comb begin
        if (grid_width_reg < DIM_MIN) begin
            w_eff = DIM_MIN;
        end else if (grid_width_reg > WidthMax) begin
            w_eff = WidthMax;
        end else begin
            w_eff = grid_width_reg;
        end
        if (grid_height_reg < DIM_MIN) begin
            h_eff = DIM_MIN;
        end else if (grid_height_reg > DIM_MAX) begin
            h_eff = DIM_MAX;
        end else begin
            h_eff = grid_height_reg;
        end
    end

    assign w_m1 = CoordWidth'(w_eff - 8'd1);
    assign h_m1 = CoordWidth'(h_eff - 8'd1);

    // input side
    assign s_xfer     = s_valid && s_ready;
    assign r0         = s_frame_start ? '0 : row_cnt_reg;
    assign c0         = s_frame_start ? '0 : col_cnt_reg;
    assign c0_inrange = {1'b0, c0} < (CoordWidth + 1)'(LineDepth);
    assign rd_addr    = AddrW'(c0);

    // window stage
    assign top_b    = s1_inrange_reg ? s1_top_reg : 1'b0;
    assign mid_b    = s1_inrange_reg ? s1_mid_reg : 1'b0;
    assign shifted  = {window_reg[7:6], s1_bit_reg, window_reg[4:3], mid_b,
                       window_reg[1:0], top_b};
    assign interior = (s1_row_reg >= 7'd2) && (s1_row_reg <= h_m1) &&
                      (s1_col_reg >= 7'd2) && (s1_col_reg <= w_m1);
    assign cnt      = pop9(shifted);

    always_comb begin
        rule_val = shifted[4];
        if (cnt >= set_thr_reg) begin
            rule_val = 1'b1;
        end
        if ($signed({1'b0, cnt}) <= $signed(clr_thr_reg)) begin
            rule_val = 1'b0;
        end
        window_next = shifted;
        if (interior) begin
            window_next[4] = rule_val;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && (!interior || out_free);
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign s1_col_m1 = s1_col_reg - 7'd1;
    assign s1_wr     = s1_adv && (s1_col_reg != '0) &&
                       ({1'b0, s1_col_m1} < (CoordWidth + 1)'(LineDepth));

    // single write port of the updated line
    assign uwe = s1_wr || pend_wr_reg;
    assign uwa = s1_wr ? AddrW'(s1_col_m1) : pend_addr_reg;
    assign uwd = s1_wr ? window_next[4] : pend_data_reg;

    always_ff @(posedge aclk) begin
        if (s_xfer && c0_inrange) begin
            original_mem[rd_addr] <= s_cell_value;
        end
        if (uwe) begin
            updated_mem[uwa] <= uwd;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_mid_reg <= original_mem[rd_addr];
            s1_top_reg <= (uwe && uwa == rd_addr) ? uwd : updated_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= RESET_DIM;
            grid_height_reg <= RESET_DIM;
            set_thr_reg     <= RESET_SET_THR;
            clr_thr_reg     <= RESET_CLR_THR;
            row_cnt_reg     <= '0;
            col_cnt_reg     <= '0;
            window_reg      <= '0;
            s1_valid_reg    <= 1'b0;
            pend_wr_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_GRID_WIDTH:      grid_width_reg  <= cfg_wdata;
                    CFG_GRID_HEIGHT:     grid_height_reg <= cfg_wdata;
                    CFG_SET_THRESHOLD:   set_thr_reg     <= cfg_wdata[SetWidth-1:0];
                    CFG_CLEAR_THRESHOLD: clr_thr_reg     <= cfg_wdata[ClearWidth-1:0];
                    default: ;
                endcase
            end

            if (s_xfer) begin
                if (c0 >= w_m1) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= (r0 >= h_m1) ? '0 : r0 + 7'd1;
                end else begin
                    col_cnt_reg <= c0 + 7'd1;
                end
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            // last column also stores its right-hand neighbour, in the following cycle
            pend_wr_reg <= s1_adv && (s1_col_reg == w_m1) &&
                           ({1'b0, s1_col_reg} < (CoordWidth + 1)'(LineDepth));

            if (s1_adv) begin
                window_reg <= window_next;
            end

            if (s1_adv && interior) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_bit_reg     <= s_cell_value;
            s1_row_reg     <= r0;
            s1_col_reg     <= c0;
            s1_inrange_reg <= c0_inrange;
        end
        pend_addr_reg <= AddrW'(s1_col_reg);
        pend_data_reg <= window_next[3];
        if (s1_adv && interior) begin
            m_out_row_reg   <= s1_row_reg - 7'd1;
            m_out_col_reg   <= s1_col_m1;
            m_new_value_reg <= rule_val;
            m_pass_done_reg <= (s1_row_reg == h_m1) && (s1_col_reg == w_m1);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_out_row_reg;
    assign m_out_col   = m_out_col_reg;
    assign m_new_value = m_new_value_reg;
    assign m_pass_done = m_pass_done_reg;

    // write port never claimed twice
    assert property (@(posedge aclk) disable iff (!aresetn) pend_wr_reg |-> !s1_wr)
        else $error("updated line write collision");

    // results only for interior cells
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_row != '0) && (m_out_col != '0))
        else $error("border cell emitted");

    // a result waits in the register while the window stage holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && s1_valid_reg && interior |-> !s_ready)
        else $error("window stage advanced into a full result register");

    // a stalled window stage keeps its cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_col_reg) && $stable(s1_row_reg))
        else $error("stalled cell lost");

endmodule

/* tb/tb.sv */
// self-checking testbench for the binary cellular automaton smoother
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcasmooth_pkg::*;

    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_CELLS   = 250;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CoordWidth-1:0] row;
        logic [CoordWidth-1:0] col;
        logic                  value;
        logic                  last;
    } cell_result_t;

    class smoothing_checker;
        logic [DimWidth-1:0]          grid_w;
        logic [DimWidth-1:0]          grid_h;
        logic [SetWidth-1:0]          set_level;
        logic signed [ClearWidth-1:0] clear_level;
        bit                           above_line[128];
        bit                           prior_line[128];
        bit [8:0]                     window3x3;
        int                           next_row;
        int                           next_col;
        cell_result_t                 due_cells[$];
        int                           mismatch_count;

        function new();
            grid_w         = RESET_DIM;
            grid_h         = RESET_DIM;
            set_level      = RESET_SET_THR;
            clear_level    = RESET_CLR_THR;
            window3x3      = '0;
            next_row       = 0;
            next_col       = 0;
            mismatch_count = 0;
        endfunction

        function int clamp_dim(int v);
            if (v < DIM_MIN) return DIM_MIN;
            if (v > DIM_MAX) return DIM_MAX;
            return v;
        endfunction

        function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_GRID_WIDTH:      grid_w = data;
                CFG_GRID_HEIGHT:     grid_h = data;
                CFG_SET_THRESHOLD:   set_level = data[SetWidth-1:0];
                CFG_CLEAR_THRESHOLD: clear_level = data[ClearWidth-1:0];
                default: ;
            endcase
        endfunction

        // notes an accepted cell and queues the update it causes, if any
        function void take_cell(bit value, bit frame_start);
            int w, h, r, c, cnt, clr;
            bit top, mid, val;
            cell_result_t res;
            w = clamp_dim(grid_w);
            h = clamp_dim(grid_h);
            if (frame_start) begin
                next_row = 0;
                next_col = 0;
            end
            r = next_row;
            c = next_col;
            top = above_line[c];
            mid = prior_line[c];
            prior_line[c] = value;
            window3x3 = {window3x3[7:6], value, window3x3[4:3], mid, window3x3[1:0], top};
            if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
                cnt = $countones(window3x3);
                clr = clear_level;
                val = window3x3[4];
                if (cnt >= int'(set_level)) val = 1'b1;
                if (cnt <= clr) val = 1'b0;
                window3x3[4] = val;
                res.row   = CoordWidth'(r - 1);
                res.col   = CoordWidth'(c - 1);
                res.value = val;
                res.last  = (r == h - 1 && c == w - 1);
                due_cells = {due_cells, res};
            end
            if (c >= 1) above_line[c-1] = window3x3[4];
            if (c == w - 1) above_line[c] = window3x3[3];
            if (c >= w - 1) begin
                next_col = 0;
                next_row = (r >= h - 1) ? 0 : r + 1;
            end else begin
                next_col = c + 1;
            end
        endfunction

        function void match_cell(cell_result_t got);
            cell_result_t want;
            if (due_cells.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: row %0d col %0d value %0d last %0d",
                             got.row, got.col, got.value, got.last);
                return;
            end
            want = due_cells.pop_front();
            if (got.row !== want.row || got.col !== want.col ||
                got.value !== want.value || got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result mismatch: expected row %0d col %0d value %0d last %0d,",
                             want.row, want.col, want.value, want.last,
                             " got row %0d col %0d value %0d last %0d",
                             got.row, got.col, got.value, got.last);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CfgIdxW-1:0]    cfg_addr = '0;
    logic [CfgDataW-1:0]   cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cell_value = 1'b0;
    logic                  s_frame_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CoordWidth-1:0] m_out_row;
    logic [CoordWidth-1:0] m_out_col;
    logic                  m_new_value;
    logic                  m_pass_done;

    smoothing_checker sb = new();
    bit idling_on = 1'b1;
    int sink_gap = 0;
    int quiet_cycles = 0;
    int cells_sent = 0;

    binary_cellular_automaton_smoother u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_value  (s_cell_value),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_new_value   (m_new_value),
        .m_pass_done   (m_pass_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            m_ready  <= (sink_gap == 1);
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(1, 5);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cell_result_t got;
        got = {m_out_row, m_out_col, m_new_value, m_pass_done};
        if (aresetn && m_valid && m_ready) sb.match_cell(got);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CfgDataW'(data);
        sb.set_register(idx, CfgDataW'(data));
        @(posedge aclk);
    endtask

    task automatic configure(input int w, input int h, input int set_thr, input int clr_thr);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_SET_THRESHOLD, set_thr);
        write_reg(CFG_CLEAR_THRESHOLD, clr_thr);
        cfg_we <= 1'b0;
    endtask

    task automatic send_cells(input int count, input bit start_first, input int density,
                              input int stray_pct);
        bit value, start;
        for (int i = 0; i < count; i++) begin
            if (idling_on && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            value = ($urandom_range(0, 99) < density);
            start = (i == 0 && start_first) || ($urandom_range(0, 99) < stray_pct);
            s_valid       <= 1'b1;
            s_cell_value  <= value;
            s_frame_start <= start;
            do @(posedge aclk); while (!s_ready);
            sb.take_cell(value, start);
            cells_sent++;
        end
    endtask

    // lets every queued update arrive, then the pipeline drain out
    task automatic settle(input int extra);
        s_valid <= 1'b0;
        while (sb.due_cells.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    initial begin
        int wv, hv, sv, cv, ew, eh, kind, dsel, density, random_start;
        int frame_cells, stray, left;
        bit prev_clean, start_first, clean;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // widest grid first so both line stores are filled, thresholds at reset values
        write_reg(CFG_GRID_WIDTH, 255);
        write_reg(CFG_GRID_HEIGHT, 0);
        cfg_we <= 1'b0;
        send_cells(128 * 3, 1'b1, 50, 0);
        settle(SETTLE_CYCLES);

        // tallest grid, always set and never clear
        configure(3, 255, 0, -16);
        send_cells(3 * 128, 1'b1, 30, 0);
        settle(SETTLE_CYCLES);

        // smallest grid, always clear, then set only on a full window and never clear
        configure(3, 3, 15, 15);
        send_cells(9, 1'b1, 100, 0);
        settle(SETTLE_CYCLES);
        configure(3, 3, 9, -1);
        send_cells(9, 1'b0, 100, 0);
        send_cells(9, 1'b0, 0, 0);
        send_cells(9, 1'b1, 50, 0);
        settle(SETTLE_CYCLES);

        // grid shrinks, then grows, part way through a frame
        configure(20, 8, 5, 3);
        send_cells(5 * 20 + 15, 1'b1, 50, 0);
        settle(SETTLE_CYCLES);
        write_reg(CFG_GRID_WIDTH, 12);
        cfg_we <= 1'b0;
        send_cells(1 + 2 * 12 + 30, 1'b0, 50, 0);
        settle(SETTLE_CYCLES);
        configure(30, 6, 6, 2);
        send_cells(24 + 3 * 30, 1'b0, 60, 0);
        settle(SETTLE_CYCLES);

        prev_clean   = 1'b0;
        random_start = cells_sent;
        while (cells_sent - random_start < RANDOM_CELLS) begin
            idling_on = (cells_sent - random_start < RANDOM_CELLS - 200) &&
                        ($urandom_range(0, 3) != 0);
            dsel = $urandom_range(0, 9);
            if (dsel == 0) wv = $urandom_range(0, 2);
            else if (dsel == 1) wv = $urandom_range(129, 255);
            else if (dsel == 2) wv = $urandom_range(17, 128);
            else wv = $urandom_range(3, 16);
            ew = sb.clamp_dim(wv);
            dsel = $urandom_range(0, 9);
            if (ew > 16) hv = $urandom_range(0, 5);
            else if (dsel == 0) hv = $urandom_range(0, 2);
            else if (dsel == 1 && ew <= 4) hv = $urandom_range(129, 255);
            else hv = $urandom_range(3, 12);
            eh = sb.clamp_dim(hv);
            dsel = $urandom_range(0, 9);
            if (dsel == 0) sv = 0;
            else if (dsel == 1) sv = 15;
            else if (dsel == 2) sv = $urandom_range(10, 14);
            else sv = $urandom_range(3, 9);
            dsel = $urandom_range(0, 9);
            if (dsel == 0) cv = -int'($urandom_range(1, 16));
            else if (dsel == 1) cv = $urandom_range(9, 15);
            else cv = $urandom_range(0, 6);
            configure(wv, hv, sv, cv);
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(0, 9);
                dsel = $urandom_range(0, 5);
                density = (dsel == 0) ? 0 : (dsel == 1) ? 100 : $urandom_range(0, 100);
                left = RANDOM_CELLS - (cells_sent - random_start);
                if (kind == 0) begin
                    frame_cells = $urandom_range(1, ew * eh - 1);
                    start_first = 1'b1;
                    stray       = 0;
                    clean       = 1'b0;
                end else if (kind == 1) begin
                    frame_cells = ew * eh;
                    start_first = 1'b1;
                    stray       = 3;
                    clean       = 1'b0;
                end else begin
                    frame_cells = ew * eh;
                    start_first = !(prev_clean && kind <= 3);
                    stray       = 0;
                    clean       = 1'b1;
                end
                // partial frame at the end of the budget
                if (frame_cells > left) begin
                    frame_cells = (left > 0) ? left : 0;
                    clean       = 1'b0;
                end
                send_cells(frame_cells, start_first, density, stray);
                prev_clean = clean;
            end
            settle(SETTLE_CYCLES);
        end

        idling_on = 1'b0;
        settle(DRAIN_CYCLES);
        if (sb.mismatch_count == 0 && sb.due_cells.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
